// ===== src/pc1_pkg.sv =====
// Shared types and constants for the PC1 byte-stream cipher.
package pc1_pkg;

    localparam int unsigned NUM_ROUNDS = 16;
    localparam int unsigned KEY_WORDS  = 4;
    localparam int unsigned PAIR_W     = 16;
    localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);
    localparam int unsigned CNT_W      = ROUND_W + 1;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [15:0] MUL_A       = 16'h4e35;
    localparam logic [15:0] MUL_B       = 16'h015a;
    localparam logic [7:0]  LETTER_BASE = 8'h61;

    typedef enum logic [2:0] {
        REG_DIRECTION  = 3'd0,
        REG_KEY_WORD_0 = 3'd1,
        REG_KEY_WORD_1 = 3'd2,
        REG_KEY_WORD_2 = 3'd3,
        REG_KEY_WORD_3 = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               clear_chain;
        logic               start_pass;
        logic               step;
        logic [ROUND_W-1:0] idx;
    } round_ctrl_t;

    typedef struct packed {
        logic       push;
        logic       two;
        logic [7:0] data0;
        logic [7:0] data1;
    } obuf_push_t;

endpackage

// ===== src/pc1_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pc1_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pc1_round.sv =====
// One cipher round per cycle while ctrl.step is set: running word, chain registers and result accumulator.
module pc1_round (
    input  logic                clk,
    input  logic                rst_n,
    input  pc1_pkg::round_ctrl_t ctrl,
    input  logic [15:0]         key_pair,
    output logic [15:0]         acc
);

    logic [15:0] w_reg, w_next;
    logic [15:0] cs_reg, cs_next;
    logic [15:0] cp_reg, cp_next;
    logic [15:0] acc_reg, acc_next;

    logic [15:0] k;
    logic [15:0] t;
    logic [31:0] prod_b;
    logic [31:0] prod_t;
    logic [31:0] prod_a;
    logic [15:0] cs_step;
    logic [15:0] w_step;

    always_comb
    begin
        k       = w_reg ^ key_pair;
        t       = cs_reg + {12'd0, ctrl.idx};
        prod_b  = {16'd0, k} * {16'd0, pc1_pkg::MUL_B};
        prod_t  = {16'd0, t} * {16'd0, pc1_pkg::MUL_A};
        prod_a  = {16'd0, k} * {16'd0, pc1_pkg::MUL_A};
        cs_step = prod_t[15:0] + prod_b[15:0] + cp_reg;
        w_step  = prod_a[15:0] + 16'd1;

        w_next   = w_reg;
        cs_next  = cs_reg;
        cp_next  = cp_reg;
        acc_next = acc_reg;
        if (ctrl.clear_chain)
        begin
            cs_next = '0;
            cp_next = '0;
        end
        if (ctrl.start_pass)
        begin
            w_next   = '0;
            acc_next = '0;
        end
        else if (ctrl.step)
        begin
            w_next   = w_step;
            cs_next  = cs_step;
            cp_next  = prod_b[15:0];
            acc_next = acc_reg ^ w_step ^ cs_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= '0;
            cs_reg  <= '0;
            cp_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            w_reg   <= w_next;
            cs_reg  <= cs_next;
            cp_reg  <= cp_next;
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== src/pc1_obuf.sv =====
// Two-entry output buffer holding the result beats of one item.
module pc1_obuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pc1_pkg::obuf_push_t  push,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 last
);

    logic [1:0] count_reg, count_next;
    logic [7:0] d0_reg, d1_reg;
    logic       last0_reg;
    logic       pop;

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push.push)
        begin
            count_next = push.two ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            d0_reg    <= push.data0;
            d1_reg    <= push.data1;
            last0_reg <= !push.two;
        end
        else if (pop)
        begin
            d0_reg    <= d1_reg;
            last0_reg <= 1'b1;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_byte  = d0_reg;
    assign last      = last0_reg;

endmodule

// ===== src/pc1_stream_cipher_256.sv =====
// Top level of the PC1 byte-stream cipher with a 256-bit evolving key.
//
// Input channel in_valid/in_stall carries data_byte and start_of_message; the
// output channel out_valid/out_stall carries out_byte and last. Registers are
// written through cfg_we/cfg_index/cfg_data: 0 direction, 1..4 key words.
// Encryption gives two letter beats per byte, decryption one byte beat per
// letter pair (the first letter of a pair gives no beat).
// The 32 key bytes sit in a 16 x 16-bit RAM as byte pairs; one round per
// cycle reads a pair, applies the pending plaintext mask and writes it back.
// A byte goes from acceptance through a round pass (a RAM read, then the
// 16 rounds), a hand-over of the results into the output buffer and an idle
// state that takes the next beat. A start-of-message beat adds a key load
// pass first. The first letter of a decrypt pair is taken without a round
// pass (after a key load if it starts a message). The first result beat is
// offered once the results are handed over.
// The next item is taken while results still wait; if the receiver stalls
// long enough the block holds the new results until the buffer is empty.
// Reset returns to idle with an all-zero key, chains and held letter.
module pc1_stream_cipher_256 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             start_of_message,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_byte,
    output logic                             last,
    input  logic                             cfg_we,
    input  logic [pc1_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pc1_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [pc1_pkg::CNT_W-1:0] LAST_LOAD =
        pc1_pkg::CNT_W'(pc1_pkg::NUM_ROUNDS - 1);
    localparam logic [pc1_pkg::CNT_W-1:0] LAST_CALC =
        pc1_pkg::CNT_W'(pc1_pkg::NUM_ROUNDS);

    pc1_pkg::state_t state_reg, state_next;
    logic [pc1_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [pc1_pkg::CNT_W-1:0] cnt_m1;

    logic                   direction_reg;
    logic [pc1_pkg::KEY_WORDS-1:0][63:0] key_reg;
    logic [7:0]             byte_reg;
    logic [7:0]             held_reg;
    logic                   waiting_reg;
    logic [7:0]             pend_reg;
    logic                   key_valid_reg;

    logic                   ram_we;
    logic [pc1_pkg::ROUND_W-1:0] ram_waddr;
    logic [pc1_pkg::ROUND_W-1:0] ram_raddr;
    logic [15:0]            ram_wdata;
    logic [15:0]            ram_rdata;

    logic [63:0]            load_word;
    logic [5:0]             load_shift;
    logic [15:0]            load_pair;
    logic [15:0]            key_pair;

    pc1_pkg::round_ctrl_t   rctl;
    pc1_pkg::obuf_push_t    push;
    logic [15:0]            acc;
    logic [7:0]             ks;
    logic [7:0]             enc_c;
    logic [7:0]             dec_hi;
    logic [7:0]             dec_lo;
    logic [7:0]             dec_c;
    logic [7:0]             plain;
    logic                   accept;

    assign accept = in_valid && !in_stall;
    assign cnt_m1 = cnt_reg - pc1_pkg::CNT_W'(1);

    // key pair r of the registers: word r/4, pair 0 in the top bits
    assign load_word  = key_reg[cnt_reg[3:2]];
    assign load_shift = {~cnt_reg[1:0], 4'b0000};
    assign load_pair  = 16'(load_word >> load_shift);
    assign key_pair   = (key_valid_reg ? ram_rdata : 16'd0) ^ {pend_reg, pend_reg};

    assign ks     = acc[15:8] ^ acc[7:0];
    assign enc_c  = byte_reg ^ ks;
    assign dec_hi = held_reg - pc1_pkg::LETTER_BASE;
    assign dec_lo = byte_reg - pc1_pkg::LETTER_BASE;
    assign dec_c  = {dec_hi[3:0], 4'b0000} + dec_lo;
    assign plain  = dec_c ^ ks;

    pc1_ram #(
        .WIDTH(pc1_pkg::PAIR_W),
        .DEPTH(pc1_pkg::NUM_ROUNDS)
    ) u_key_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    pc1_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rctl),
        .key_pair(key_pair),
        .acc     (acc)
    );

    pc1_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte (out_byte),
        .last     (last)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pc1_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_of_message)
                    begin
                        state_next = pc1_pkg::ST_LOAD;
                    end
                    else if (!direction_reg || waiting_reg)
                    begin
                        state_next = pc1_pkg::ST_CALC;
                    end
                end
            end
            pc1_pkg::ST_LOAD:
            begin
                if (cnt_reg == LAST_LOAD)
                begin
                    state_next = direction_reg ? pc1_pkg::ST_IDLE : pc1_pkg::ST_CALC;
                end
            end
            pc1_pkg::ST_CALC:
            begin
                if (cnt_reg == LAST_CALC)
                begin
                    state_next = pc1_pkg::ST_EMIT;
                end
            end
            pc1_pkg::ST_EMIT:
            begin
                if (!out_valid)
                begin
                    state_next = pc1_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pc1_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall         = 1'b1;
        cnt_next         = '0;
        ram_we           = 1'b0;
        ram_waddr        = cnt_reg[pc1_pkg::ROUND_W-1:0];
        ram_wdata        = load_pair;
        ram_raddr        = cnt_reg[pc1_pkg::ROUND_W-1:0];
        rctl.clear_chain = 1'b0;
        rctl.start_pass  = 1'b0;
        rctl.step        = 1'b0;
        rctl.idx         = cnt_m1[pc1_pkg::ROUND_W-1:0];
        push.push        = 1'b0;
        push.two         = !direction_reg;
        push.data0       = direction_reg ? plain : pc1_pkg::LETTER_BASE + {4'd0, enc_c[7:4]};
        push.data1       = pc1_pkg::LETTER_BASE + {4'd0, enc_c[3:0]};
        case (state_reg)
            pc1_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            pc1_pkg::ST_LOAD:
            begin
                ram_we           = 1'b1;
                rctl.clear_chain = 1'b1;
                cnt_next         = (cnt_reg == LAST_LOAD) ? '0 : cnt_reg + pc1_pkg::CNT_W'(1);
            end
            pc1_pkg::ST_CALC:
            begin
                cnt_next = cnt_reg + pc1_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rctl.start_pass = 1'b1;
                end
                else
                begin
                    rctl.step = 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m1[pc1_pkg::ROUND_W-1:0];
                    ram_wdata = key_pair;
                end
            end
            pc1_pkg::ST_EMIT:
            begin
                push.push = !out_valid;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pc1_pkg::ST_IDLE;
            cnt_reg       <= '0;
            direction_reg <= 1'b0;
            key_reg       <= '0;
            held_reg      <= '0;
            waiting_reg   <= 1'b0;
            pend_reg      <= '0;
            key_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pc1_pkg::REG_DIRECTION:  direction_reg <= cfg_data[0];
                    pc1_pkg::REG_KEY_WORD_0: key_reg[0]    <= cfg_data;
                    pc1_pkg::REG_KEY_WORD_1: key_reg[1]    <= cfg_data;
                    pc1_pkg::REG_KEY_WORD_2: key_reg[2]    <= cfg_data;
                    pc1_pkg::REG_KEY_WORD_3: key_reg[3]    <= cfg_data;
                    default:                 key_reg       <= key_reg;
                endcase
            end
            if (accept && !start_of_message && direction_reg && !waiting_reg)
            begin
                held_reg    <= data_byte;
                waiting_reg <= 1'b1;
            end
            if (state_reg == pc1_pkg::ST_LOAD && cnt_reg == LAST_LOAD)
            begin
                pend_reg      <= '0;
                key_valid_reg <= 1'b1;
                held_reg      <= direction_reg ? byte_reg : 8'd0;
                waiting_reg   <= direction_reg;
            end
            if (state_reg == pc1_pkg::ST_CALC && cnt_reg == LAST_CALC)
            begin
                key_valid_reg <= 1'b1;
            end
            if (push.push)
            begin
                pend_reg <= direction_reg ? plain : byte_reg;
                if (direction_reg)
                begin
                    held_reg    <= '0;
                    waiting_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

    a_pass_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pc1_pkg::ST_CALC && cnt_reg == LAST_CALC)
            |=> state_reg == pc1_pkg::ST_EMIT)
        else $error("round pass did not end in result hand-over");

    a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !out_valid)
        else $error("results pushed into a busy output buffer");

    a_key_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid_reg |=> key_valid_reg)
        else $error("key store valid flag dropped");

    a_decrypt_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pc1_pkg::ST_EMIT && direction_reg) |-> waiting_reg)
        else $error("decrypt result without a held letter");

endmodule
